// ===== src/rmsc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmsc_pkg
// Shared types and constants of the RSA modular exponentiation symbol cipher.
// ---------------------------------------------------------------------------
package rmsc_pkg;

	// configuration register index
	localparam int REG_IDX_W = 2;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_MODULUS      = 2'd0;
	localparam reg_idx_t REG_ENCRYPT_EXP  = 2'd1;
	localparam reg_idx_t REG_DECRYPT_EXP  = 2'd2;
	localparam reg_idx_t REG_SYMBOL_OFS   = 2'd3;

	// reset values of the registers
	localparam logic [31:0] RST_MODULUS     = 32'd3233;
	localparam logic [31:0] RST_ENCRYPT_EXP = 32'd17;
	localparam logic [31:0] RST_DECRYPT_EXP = 32'd2753;
	localparam logic [7:0]  RST_SYMBOL_OFS  = 8'd96;

	// symbol offset width
	localparam int OFS_W = 8;

	// item modes
	localparam logic MODE_ENCRYPT = 1'b0;
	localparam logic MODE_DECRYPT = 1'b1;

	// multiply operand select
	localparam logic MUL_SQUARE = 1'b0;
	localparam logic MUL_BASE   = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic div_step;
		logic fix;
		logic mul_load;
		logic mul_sel;
		logic mul_step;
		logic mul_wb;
		logic exp_shift;
		logic store;
	} rmsc_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic mod_zero;
		logic exp_msb;
	} rmsc_stat_t;

endpackage

// ===== src/rmsc_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmsc_if
// Valid/ready channels of the cipher: input items, results, register writes.
// ---------------------------------------------------------------------------
interface rmsc_in_if #(parameter int DATA_WIDTH = 32);
	logic                  valid;
	logic                  ready;
	logic                  mode;
	logic [DATA_WIDTH-1:0] value;

	modport source (output valid, mode, value, input ready);
	modport sink   (input valid, mode, value, output ready);
endinterface

interface rmsc_out_if #(parameter int DATA_WIDTH = 32);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] residue;
	logic [DATA_WIDTH:0]   symbol_code;

	modport source (output valid, residue, symbol_code, input ready);
	modport sink   (input valid, residue, symbol_code, output ready);
endinterface

interface rmsc_cfg_if #(parameter int DATA_WIDTH = 32);
	logic                          valid;
	logic                          ready;
	logic [rmsc_pkg::REG_IDX_W-1:0] index;
	logic [DATA_WIDTH-1:0]         data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/rmsc_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmsc_datapath
// Serial remainder unit, shift-and-add modular multiplier and exponent
// register, stepped by the controller one bit per cycle.
// ---------------------------------------------------------------------------
module rmsc_datapath #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  rmsc_pkg::rmsc_cmd_t           cmd,
	output rmsc_pkg::rmsc_stat_t          stat,
	input  logic                          in_mode,
	input  logic [DATA_WIDTH-1:0]         in_value,
	input  logic [DATA_WIDTH-1:0]         modulus,
	input  logic [DATA_WIDTH-1:0]         encrypt_exponent,
	input  logic [DATA_WIDTH-1:0]         decrypt_exponent,
	input  logic [rmsc_pkg::OFS_W-1:0]    symbol_offset,
	output logic [DATA_WIDTH-1:0]         result
);
	import rmsc_pkg::*;

	localparam int W = DATA_WIDTH;

	logic         neg_q;
	logic [W-1:0] x_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] exp_q;
	logic [W-1:0] base_q;
	logic [W-1:0] r_q;
	logic [W-1:0] acc_q;
	logic [W-1:0] ma_q;
	logic [W-1:0] mb_q;

	logic [W-1:0] ofs_ext;
	logic         below;
	logic [W:0]   div_s;
	logic [W-1:0] div_r;
	logic [W:0]   dbl_s;
	logic [W-1:0] dbl_r;
	logic [W:0]   add_s;
	logic [W-1:0] add_r;

	assign ofs_ext = W'(symbol_offset);
	assign below   = (in_mode == MODE_ENCRYPT) && (in_value < ofs_ext);

	// one restoring remainder step
	always_comb begin
		div_s = {rem_q, x_q[W-1]};
		div_r = (div_s >= {1'b0, modulus}) ? W'(div_s - {1'b0, modulus}) : div_s[W-1:0];
	end

	// doubling then optional add, both reduced by the modulus
	always_comb begin
		dbl_s = {acc_q, 1'b0};
		dbl_r = (dbl_s >= {1'b0, modulus}) ? W'(dbl_s - {1'b0, modulus}) : dbl_s[W-1:0];
		add_s = {1'b0, dbl_r} + {1'b0, ma_q};
		add_r = (add_s >= {1'b0, modulus}) ? W'(add_s - {1'b0, modulus}) : add_s[W-1:0];
	end

	// operand and working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= below;
			rem_q <= '0;
			r_q   <= '0;
			if (in_mode == MODE_DECRYPT) begin
				x_q   <= in_value;
				exp_q <= decrypt_exponent;
			end else begin
				x_q   <= below ? (ofs_ext - in_value) : (in_value - ofs_ext);
				exp_q <= encrypt_exponent;
			end
		end
		if (cmd.div_step) begin
			rem_q <= div_r;
			x_q   <= {x_q[W-2:0], 1'b0};
		end
		if (cmd.fix) begin
			base_q <= (neg_q && (rem_q != '0)) ? (modulus - rem_q) : rem_q;
			r_q    <= (modulus == W'(1)) ? '0 : W'(1);
		end
		if (cmd.mul_load) begin
			ma_q  <= r_q;
			mb_q  <= (cmd.mul_sel == MUL_BASE) ? base_q : r_q;
			acc_q <= '0;
		end
		if (cmd.mul_step) begin
			acc_q <= mb_q[W-1] ? add_r : dbl_r;
			mb_q  <= {mb_q[W-2:0], 1'b0};
		end
		if (cmd.mul_wb) begin
			r_q <= acc_q;
		end
		if (cmd.exp_shift) begin
			exp_q <= {exp_q[W-2:0], 1'b0};
		end
	end

	assign stat.mod_zero = (modulus == '0);
	assign stat.exp_msb  = exp_q[W-1];
	assign result        = r_q;

endmodule

// ===== src/rmsc_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmsc_ctrl
// Sequencer: base reduction, then square-and-multiply over the exponent bits.
// ---------------------------------------------------------------------------
module rmsc_ctrl #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 out_free,
	input  rmsc_pkg::rmsc_stat_t stat,
	output rmsc_pkg::rmsc_cmd_t  cmd
);
	import rmsc_pkg::*;

	localparam int CW = $clog2(DATA_WIDTH);
	localparam logic [CW-1:0] LAST = CW'(DATA_WIDTH - 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_FIX   = 3'd2;
	localparam logic [2:0] S_MLD   = 3'd3;
	localparam logic [2:0] S_MSTEP = 3'd4;
	localparam logic [2:0] S_MWB   = 3'd5;
	localparam logic [2:0] S_STORE = 3'd6;

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] ecnt_q, ecnt_d;
	logic          phase_q, phase_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		ecnt_d   = ecnt_q;
		phase_d  = phase_q;
		cmd      = '0;
		in_ready = 1'b0;
		cmd.mul_sel = phase_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = stat.mod_zero ? S_STORE : S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + CW'(1);
				if (cnt_q == LAST) state_d = S_FIX;
			end
			S_FIX: begin
				cmd.fix = 1'b1;
				ecnt_d  = '0;
				phase_d = MUL_SQUARE;
				state_d = S_MLD;
			end
			S_MLD: begin
				cmd.mul_load = 1'b1;
				cnt_d        = '0;
				state_d      = S_MSTEP;
			end
			S_MSTEP: begin
				cmd.mul_step = 1'b1;
				cnt_d        = cnt_q + CW'(1);
				if (cnt_q == LAST) state_d = S_MWB;
			end
			S_MWB: begin
				cmd.mul_wb = 1'b1;
				if ((phase_q == MUL_SQUARE) && stat.exp_msb) begin
					phase_d = MUL_BASE;
					state_d = S_MLD;
				end else begin
					phase_d       = MUL_SQUARE;
					cmd.exp_shift = 1'b1;
					ecnt_d        = ecnt_q + CW'(1);
					state_d       = (ecnt_q == LAST) ? S_STORE : S_MLD;
				end
			end
			S_STORE: begin
				if (out_free) begin
					cmd.store = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			ecnt_q  <= '0;
			phase_q <= MUL_SQUARE;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ecnt_q  <= ecnt_d;
			phase_q <= phase_d;
		end
	end

endmodule

// ===== src/rsa_modexp_symbol_cipher.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsa_modexp_symbol_cipher
// Textbook RSA modular exponentiation on one symbol per item.
// ---------------------------------------------------------------------------
// Usage:
//   cfg  : register writes (modulus, encrypt/decrypt exponent, symbol offset),
//          always ready; write only while no item is in flight.
//   din  : one transfer per item (mode, value); ready only while idle.
//   dout : one transfer per item (residue, symbol_code = residue + offset).
// Sequence (W = DATA_WIDTH):
//   a load step, W remainder steps, a fix step, then for every exponent bit
//   one modular square plus one modular multiply when the bit is set, each
//   a load step, one step per multiplier bit and a write-back, then a store
//   step; the shift-and-add multiplier handles one multiplier bit per cycle.
//   A zero modulus skips the arithmetic and goes straight to the store step.
// Reset loads the register defaults (3233, 17, 2753, 96) and empties the
// result register. When the receiver stalls, a finished result waits in the
// output register and the next item is still taken; its result waits for
// the slot to free.
// ---------------------------------------------------------------------------
module rsa_modexp_symbol_cipher #(
	parameter int DATA_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	rmsc_cfg_if.sink   cfg,
	rmsc_in_if.sink    din,
	rmsc_out_if.source dout
);
	import rmsc_pkg::*;

	localparam int W = DATA_WIDTH;

	logic [W-1:0]     modulus_q;
	logic [W-1:0]     enc_exp_q;
	logic [W-1:0]     dec_exp_q;
	logic [OFS_W-1:0] ofs_q;

	logic             out_valid_q;
	logic [W-1:0]     residue_q;
	logic [W:0]       code_q;

	rmsc_cmd_t        cmd;
	rmsc_stat_t       stat;
	logic [W-1:0]     result;
	logic             out_free;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= W'(RST_MODULUS);
			enc_exp_q <= W'(RST_ENCRYPT_EXP);
			dec_exp_q <= W'(RST_DECRYPT_EXP);
			ofs_q     <= RST_SYMBOL_OFS;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MODULUS:     modulus_q <= cfg.data;
				REG_ENCRYPT_EXP: enc_exp_q <= cfg.data;
				REG_DECRYPT_EXP: dec_exp_q <= cfg.data;
				REG_SYMBOL_OFS:  ofs_q     <= cfg.data[OFS_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || dout.ready;

	rmsc_ctrl #(.DATA_WIDTH(W)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (din.ready),
		.out_free (out_free),
		.stat     (stat),
		.cmd      (cmd)
	);

	rmsc_datapath #(.DATA_WIDTH(W)) u_datapath (
		.clk              (clk),
		.cmd              (cmd),
		.stat             (stat),
		.in_mode          (din.mode),
		.in_value         (din.value),
		.modulus          (modulus_q),
		.encrypt_exponent (enc_exp_q),
		.decrypt_exponent (dec_exp_q),
		.symbol_offset    (ofs_q),
		.result           (result)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.store) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			residue_q <= result;
			code_q    <= {1'b0, result} + (W + 1)'(ofs_q);
		end
	end

	assign dout.valid       = out_valid_q;
	assign dout.residue     = residue_q;
	assign dout.symbol_code = code_q;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the RSA modular exponentiation symbol cipher.
// A directed pass covers the textbook key, zero exponents, degenerate moduli
// and full-width operands. Randomised key settings and symbols follow under
// four idling patterns. Each result is compared with a typed value or an in-bench predictor.
// ---------------------------------------------------------------------------
module tb;
	import rmsc_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 64;
	localparam int SEG_ITEMS      = 34;
	localparam int N_DIRECTED     = 27;

	typedef struct packed {
		logic [31:0] residue;
		logic [32:0] symbol_code;
	} cipher_out_t;

	typedef enum logic {ROW_WRITE, ROW_ITEM} row_op_t;

	typedef struct {
		row_op_t     op;
		reg_idx_t    idx;
		logic [31:0] data;
		logic        mode;
		logic        fixed;
		logic [31:0] residue;
		logic [32:0] code;
	} dir_row_t;

	logic clk;
	logic arst_n;

	rmsc_cfg_if #(.DATA_WIDTH(32)) cfg ();
	rmsc_in_if  #(.DATA_WIDTH(32)) din ();
	rmsc_out_if #(.DATA_WIDTH(32)) dout ();

	rsa_modexp_symbol_cipher #(.DATA_WIDTH(32)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.din    (din),
		.dout   (dout)
	);

	// key registers as the bench believes them to be
	logic [31:0] key_modulus;
	logic [31:0] key_enc_exp;
	logic [31:0] key_dec_exp;
	logic [7:0]  key_offset;

	cipher_out_t expected_symbols [$];
	logic [31:0] last_cipher;
	int          src_idle_pct;
	int          snk_stall_pct;
	int          errors;
	int          items_sent;
	int          results_seen;
	int          reg_writes;
	int          quiet_cycles;

	// directed stimulus; typed results where the answer is plain
	dir_row_t directed_rows [N_DIRECTED] = '{
		// textbook key after reset
		'{ROW_ITEM,  REG_MODULUS,     32'd96,        MODE_ENCRYPT, 1'b1, 32'd0,    33'd96},
		'{ROW_ITEM,  REG_MODULUS,     32'd161,       MODE_ENCRYPT, 1'b1, 32'd2790, 33'd2886},
		'{ROW_ITEM,  REG_MODULUS,     32'd2790,      MODE_DECRYPT, 1'b1, 32'd65,   33'd161},
		'{ROW_ITEM,  REG_MODULUS,     32'd0,         MODE_DECRYPT, 1'b1, 32'd0,    33'd96},
		// character below the offset wraps by floored modulo, then full-width values
		'{ROW_ITEM,  REG_MODULUS,     32'd0,         MODE_ENCRYPT, 1'b0, 32'd0,    33'd0},
		'{ROW_ITEM,  REG_MODULUS,     32'hFFFF_FFFF, MODE_ENCRYPT, 1'b0, 32'd0,    33'd0},
		'{ROW_ITEM,  REG_MODULUS,     32'hFFFF_FFFF, MODE_DECRYPT, 1'b0, 32'd0,    33'd0},
		// zero exponents give one
		'{ROW_WRITE, REG_ENCRYPT_EXP, 32'd0,         MODE_ENCRYPT, 1'b0, 32'd0,    33'd0},
		'{ROW_WRITE, REG_DECRYPT_EXP, 32'd0,         MODE_ENCRYPT, 1'b0, 32'd0,    33'd0},
		'{ROW_ITEM,  REG_MODULUS,     32'd12345,     MODE_ENCRYPT, 1'b1, 32'd1,    33'd97},
		'{ROW_ITEM,  REG_MODULUS,     32'd0,         MODE_DECRYPT, 1'b1, 32'd1,    33'd97},
		// modulus one clears every residue
		'{ROW_WRITE, REG_MODULUS,     32'd1,         MODE_ENCRYPT, 1'b0, 32'd0,    33'd0},
		'{ROW_ITEM,  REG_MODULUS,     32'd500,       MODE_ENCRYPT, 1'b1, 32'd0,    33'd96},
		// zero modulus returns the bare offset
		'{ROW_WRITE, REG_MODULUS,     32'd0,         MODE_ENCRYPT, 1'b0, 32'd0,    33'd0},
		'{ROW_WRITE, REG_SYMBOL_OFS,  32'd255,       MODE_ENCRYPT, 1'b0, 32'd0,    33'd0},
		'{ROW_ITEM,  REG_MODULUS,     32'hDEAD_BEEF, MODE_DECRYPT, 1'b1, 32'd0,    33'd255},
		// all-ones modulus and exponents, zero offset
		'{ROW_WRITE, REG_MODULUS,     32'hFFFF_FFFF, MODE_ENCRYPT, 1'b0, 32'd0,    33'd0},
		'{ROW_WRITE, REG_ENCRYPT_EXP, 32'hFFFF_FFFF, MODE_ENCRYPT, 1'b0, 32'd0,    33'd0},
		'{ROW_WRITE, REG_DECRYPT_EXP, 32'hFFFF_FFFF, MODE_ENCRYPT, 1'b0, 32'd0,    33'd0},
		'{ROW_WRITE, REG_SYMBOL_OFS,  32'd0,         MODE_ENCRYPT, 1'b0, 32'd0,    33'd0},
		'{ROW_ITEM,  REG_MODULUS,     32'hFFFF_FFFF, MODE_ENCRYPT, 1'b1, 32'd0,    33'd0},
		'{ROW_ITEM,  REG_MODULUS,     32'd0,         MODE_ENCRYPT, 1'b0, 32'd0,    33'd0},
		'{ROW_ITEM,  REG_MODULUS,     32'hFFFF_FFFE, MODE_DECRYPT, 1'b0, 32'd0,    33'd0},
		// modulus two with the largest offset
		'{ROW_WRITE, REG_MODULUS,     32'd2,         MODE_ENCRYPT, 1'b0, 32'd0,    33'd0},
		'{ROW_WRITE, REG_SYMBOL_OFS,  32'd255,       MODE_ENCRYPT, 1'b0, 32'd0,    33'd0},
		'{ROW_ITEM,  REG_MODULUS,     32'd0,         MODE_ENCRYPT, 1'b0, 32'd0,    33'd0},
		'{ROW_ITEM,  REG_MODULUS,     32'd1,         MODE_DECRYPT, 1'b0, 32'd0,    33'd0}
	};

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// right-to-left square-and-multiply, every step reduced mod n (n >= 1)
	function automatic logic [31:0] mod_pow(logic [31:0] b, logic [31:0] e, logic [31:0] n);
		logic [63:0] acc;
		logic [63:0] sq;
		acc = (n == 32'd1) ? 64'd0 : 64'd1;
		sq  = 64'(b);
		for (int i = 0; i < 32; i++) begin
			if (e[i])
				acc = (acc * sq) % 64'(n);
			sq = (sq * sq) % 64'(n);
		end
		return acc[31:0];
	endfunction

	// expected result of one symbol under the current key
	function automatic cipher_out_t predict_symbol(logic mode, logic [31:0] value);
		logic [63:0] n;
		logic [63:0] base;
		logic [63:0] wrap;
		logic [31:0] res;
		cipher_out_t o;
		n   = 64'(key_modulus);
		res = '0;
		if (n != 0) begin
			if (mode == MODE_ENCRYPT) begin
				if (value >= 32'(key_offset)) begin
					base = 64'(value - 32'(key_offset)) % n;
				end else begin
					wrap = 64'(32'(key_offset) - value) % n;
					base = (wrap == 0) ? 64'd0 : n - wrap;
				end
				res = mod_pow(base[31:0], key_enc_exp, key_modulus);
			end else begin
				res = mod_pow(value % key_modulus, key_dec_exp, key_modulus);
			end
		end
		o.residue     = res;
		o.symbol_code = {1'b0, res} + 33'(key_offset);
		return o;
	endfunction

	// one register write transfer; valid is left high for back-to-back writes
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_MODULUS:     key_modulus = data;
			REG_ENCRYPT_EXP: key_enc_exp = data;
			REG_DECRYPT_EXP: key_dec_exp = data;
			REG_SYMBOL_OFS:  key_offset  = data[7:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	// one symbol transfer, with optional sender gaps in front of it
	task automatic send_item(input logic mode, input logic [31:0] value,
			input logic use_fixed, input cipher_out_t fixed_out);
		cipher_out_t p;
		cfg.valid <= 1'b0;
		while ($urandom_range(99) < src_idle_pct) begin
			din.valid <= 1'b0;
			@(posedge clk);
		end
		din.valid <= 1'b1;
		din.mode  <= mode;
		din.value <= value;
		do @(posedge clk); while (!din.ready);
		p = use_fixed ? fixed_out : predict_symbol(mode, value);
		expected_symbols.push_back(p);
		if (mode == MODE_ENCRYPT)
			last_cipher = p.residue;
		items_sent++;
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain_results();
		din.valid <= 1'b0;
		cfg.valid <= 1'b0;
		do @(posedge clk); while (expected_symbols.size() != 0);
	endtask

	// fresh random key, written while the block is idle
	task automatic load_random_key();
		logic [31:0] n;
		logic [31:0] e;
		logic [31:0] d;
		logic [31:0] ofs;
		drain_results();
		case ($urandom_range(11))
			0:       n = $urandom_range(2, 255);
			1:       n = 32'd3233;
			2:       n = 32'hFFFF_FFFF;
			3:       n = $urandom_range(0, 1);
			4:       n = 32'd2;
			5, 6, 7: n = $urandom;
			default: n = $urandom_range(256, 65535);
		endcase
		case ($urandom_range(7))
			0:       e = 32'd0;
			1:       e = 32'hFFFF_FFFF;
			2, 3:    e = $urandom_range(1, 65537);
			default: e = $urandom;
		endcase
		case ($urandom_range(7))
			0:       d = 32'd0;
			1:       d = 32'hFFFF_FFFF;
			2, 3:    d = $urandom_range(1, 65537);
			default: d = $urandom;
		endcase
		case ($urandom_range(3))
			0:       ofs = 32'd0;
			1:       ofs = 32'd255;
			default: ofs = $urandom_range(0, 255);
		endcase
		write_reg(REG_MODULUS, n);
		write_reg(REG_ENCRYPT_EXP, e);
		write_reg(REG_DECRYPT_EXP, d);
		write_reg(REG_SYMBOL_OFS, ofs);
	endtask

	// receiver: ready with the current stall rate
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dout.ready <= 1'b0;
		else
			dout.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// result checker
	always @(posedge clk) begin
		cipher_out_t want;
		if (arst_n && dout.valid && dout.ready) begin
			results_seen++;
			if (expected_symbols.size() == 0) begin
				$error("result with nothing expected: residue %0d, symbol_code %0d",
					dout.residue, dout.symbol_code);
				errors++;
			end else begin
				want = expected_symbols.pop_front();
				if (dout.residue !== want.residue) begin
					$error("residue mismatch: expected %0d, got %0d",
						want.residue, dout.residue);
					errors++;
				end
				if (dout.symbol_code !== want.symbol_code) begin
					$error("symbol_code mismatch: expected %0d, got %0d",
						want.symbol_code, dout.symbol_code);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (din.valid && din.ready) || (dout.valid && dout.ready)
				|| (cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				quiet_cycles, expected_symbols.size());
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// main sequence
	initial begin
		logic        mode;
		logic [31:0] value;
		clk           = 1'b0;
		arst_n        = 1'b0;
		din.valid     = 1'b0;
		din.mode      = MODE_ENCRYPT;
		din.value     = '0;
		cfg.valid     = 1'b0;
		cfg.index     = REG_MODULUS;
		cfg.data      = '0;
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		items_sent    = 0;
		reg_writes    = 0;
		last_cipher   = '0;
		key_modulus   = RST_MODULUS;
		key_enc_exp   = RST_ENCRYPT_EXP;
		key_dec_exp   = RST_DECRYPT_EXP;
		key_offset    = RST_SYMBOL_OFS;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pass, no idling
		for (int i = 0; i < N_DIRECTED; i++) begin
			if (directed_rows[i].op == ROW_WRITE) begin
				if (i > 0 && directed_rows[i-1].op == ROW_ITEM)
					drain_results();
				write_reg(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				send_item(directed_rows[i].mode, directed_rows[i].data,
					directed_rows[i].fixed,
					{directed_rows[i].residue, directed_rows[i].code});
			end
		end

		// random pass: four idling patterns, two keys each
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 72; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 72; end
				default: begin src_idle_pct = 10; snk_stall_pct = 10; end
			endcase
			for (int seg = 0; seg < 2; seg++) begin
				load_random_key();
				for (int k = 0; k < SEG_ITEMS; k++) begin
					// hold off now and then until the pipeline is empty
					if (k == 17 || $urandom_range(39) == 0)
						drain_results();
					mode = 1'($urandom_range(1));
					if (mode == MODE_ENCRYPT) begin
						case ($urandom_range(3))
							0:       value = key_offset + $urandom_range(0, 95);
							1:       value = $urandom_range(0, key_offset);
							default: value = $urandom;
						endcase
					end else begin
						case ($urandom_range(3))
							0:       value = last_cipher;
							1:       value = (key_modulus != 0) ? $urandom % key_modulus
								: $urandom;
							default: value = $urandom;
						endcase
					end
					send_item(mode, value, 1'b0, '0);
				end
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run covered %0d symbols over 4 idling patterns and %0d register writes",
			items_sent, reg_writes);
		$display("%0d results checked, %0d mismatches", results_seen, errors);
		if (errors == 0 && expected_symbols.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/rmsc_pkg.sv
src/rmsc_if.sv
src/rmsc_datapath.sv
src/rmsc_ctrl.sv
src/rsa_modexp_symbol_cipher.sv
tb/tb.sv
